FILE: rtl/allocation_tracking_table_macros.svh
// Assertion macros used by the allocation tracking table checker.
`ifndef ALLOCATION_TRACKING_TABLE_MACROS_SVH
`define ALLOCATION_TRACKING_TABLE_MACROS_SVH

// Concurrent assertion on clk, switched off while reset is asserted.
`define AAT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Concurrent assertion on clk that is also checked during reset.
`define AAT_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: rtl/aat_pkg.sv
// Shared types and constants of the allocation tracking table.
package aat_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = 64;
	localparam int SIZE_W      = 32;
	localparam int MODE_W      = 2;

	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] block_address;
		logic [SIZE_W-1:0] block_size;
	} req_t;

	typedef struct packed {
		logic              status;
		logic              has_entry;
		logic [ADDR_W-1:0] entry_address;
		logic [SIZE_W-1:0] entry_size;
		logic              last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_req;
		logic exec;
		logic rd_issue;
		logic scan_step;
		logic ld_entry;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_report;
		logic any_used;
		logic cur_used;
		logic rest_used;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/aat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/aat_ctrl.sv
// Controller state machine of the allocation tracking table.
module aat_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  aat_pkg::sts_t sts,
	output aat_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_RSCAN = 4'b0100,
		ST_RREAD = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.ld_req = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_report && sts.any_used) begin
					state_d = ST_RSCAN;
				end else if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RSCAN: begin
				if (sts.cur_used) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_RREAD;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_RREAD: begin
				if (sts.out_free) begin
					cmd.ld_entry  = 1'b1;
					cmd.scan_step = 1'b1;
					state_d       = sts.rest_used ? ST_RSCAN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/aat_datapath.sv
// Datapath of the allocation tracking table: slot registers, match, scan and result buffer.
module aat_datapath #(
	parameter int DEPTH = aat_pkg::TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  aat_pkg::req_t req,
	input  aat_pkg::cmd_t cmd,
	output aat_pkg::sts_t sts,
	input  logic          rsp_ready,
	output logic          rsp_valid,
	output aat_pkg::rsp_t rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int ENT_W = aat_pkg::ADDR_W + aat_pkg::SIZE_W;

	aat_pkg::req_t             req_q;
	logic [DEPTH-1:0]          used_q;
	logic [aat_pkg::ADDR_W-1:0] slot_addr_q [DEPTH];
	logic [DEPTH-1:0]          match_s1;
	logic [DEPTH-1:0]          scan_q;
	logic [IDX_W-1:0]          idx_q;
	aat_pkg::rsp_t             out_q;
	logic                      out_valid_q;

	logic [DEPTH-1:0] free_v;
	logic [DEPTH-1:0] free_oh;
	logic [DEPTH-1:0] match_oh;
	logic [IDX_W-1:0] free_idx;
	logic             any_free;
	logic             any_match;
	logic             addr_null;
	logic             size_zero;
	logic             fail;
	logic             do_store;
	logic             do_clear;
	logic [ENT_W-1:0] ram_rdata;

	// Lowest set bit isolated by the two's complement trick.
	assign free_v    = ~used_q;
	assign free_oh   = free_v & (~free_v + DEPTH'(1));
	assign match_oh  = match_s1 & (~match_s1 + DEPTH'(1));
	assign any_free  = |free_v;
	assign any_match = |match_s1;
	assign addr_null = (req_q.block_address == '0);
	assign size_zero = (req_q.block_size == '0);

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (free_oh[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		fail     = 1'b1;
		do_store = 1'b0;
		do_clear = 1'b0;
		case (req_q.mode)
			aat_pkg::MODE_APPEND: begin
				fail     = addr_null || (!size_zero && !any_free);
				do_store = !addr_null && !size_zero && any_free;
			end
			aat_pkg::MODE_REMOVE: begin
				fail     = addr_null || !any_match;
				do_clear = !addr_null && any_match;
			end
			aat_pkg::MODE_REPORT: begin
				fail = 1'b0;
			end
			default: begin
				fail = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_q <= req;
			for (int i = 0; i < DEPTH; i++) begin
				match_s1[i] <= used_q[i] && (slot_addr_q[i] == req.block_address);
			end
		end
		if (cmd.exec && do_store) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (free_oh[i]) begin
					slot_addr_q[i] <= req_q.block_address;
				end
			end
		end
		if (cmd.ld_req) begin
			scan_q <= used_q;
			idx_q  <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q >> 1;
			idx_q  <= idx_q + IDX_W'(1);
		end
		if (cmd.exec) begin
			out_q.status        <= fail;
			out_q.has_entry     <= 1'b0;
			out_q.entry_address <= '0;
			out_q.entry_size    <= '0;
			out_q.last          <= 1'b1;
		end else if (cmd.ld_entry) begin
			out_q.status        <= 1'b0;
			out_q.has_entry     <= 1'b1;
			out_q.entry_address <= ram_rdata[ENT_W-1:aat_pkg::SIZE_W];
			out_q.entry_size    <= ram_rdata[aat_pkg::SIZE_W-1:0];
			out_q.last          <= !sts.rest_used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && do_store) begin
				used_q <= used_q | free_oh;
			end else if (cmd.exec && do_clear) begin
				used_q <= used_q & ~match_oh;
			end
			if (cmd.exec || cmd.ld_entry) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Copy of address and size for the report scan.
	aat_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.exec && do_store),
		.waddr(free_idx),
		.wdata({req_q.block_address, req_q.block_size}),
		.re   (cmd.rd_issue),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign sts.is_report = (req_q.mode == aat_pkg::MODE_REPORT);
	assign sts.any_used  = |used_q;
	assign sts.cur_used  = scan_q[0];
	assign sts.rest_used = |scan_q[DEPTH-1:1];
	assign sts.out_free  = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: rtl/allocation_tracking_table.sv
// Allocation tracking table: append, remove and report over a fixed slot table.
// Append, remove and an undefined mode are accepted in idle and answered from the
// execute state once the result register is free. A report walks the slots up to the
// last used one and reads each used slot from the slot RAM, one result per used slot.
// Reset clears all used marks at once; addresses and sizes are undefined until written.
// A new request is taken once the previous one is done, even while its result waits.
module allocation_tracking_table #(
	parameter int DEPTH = aat_pkg::TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  aat_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output aat_pkg::rsp_t rsp
);

	// Commands from the controller and status back from the datapath.
	aat_pkg::cmd_t cmd;
	aat_pkg::sts_t sts;

	// The controller sequences one request at a time. Remove is resolved by a
	// parallel address match that is registered at acceptance, then applied in
	// the execute cycle; append takes the lowest free slot. A report walks a
	// shifted copy of the used marks and reads each used slot from the slot RAM.
	aat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the slot table, the match vector, the scan state and
	// the result register that decouples the result side from the request side.
	aat_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_ready(rsp_ready),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/aat_checker.sv
// Port-level checker for the allocation tracking table and its bind.
`include "allocation_tracking_table_macros.svh"

module aat_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input aat_pkg::rsp_t rsp
);

	// A stalled result holds still.
	`AAT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "result changed while stalled")

	// Results without an entry always close their request.
	`AAT_ASSERT(a_plain_last, rsp_valid && !rsp.has_entry |-> rsp.last, "plain result not last")

	// Reported entries are successes and never carry a null address.
	`AAT_ASSERT(a_entry_ok, rsp_valid && rsp.has_entry |-> !rsp.status && rsp.entry_address != 64'd0, "bad entry")

	// Only one request is worked on at a time.
	`AAT_ASSERT(a_one_req, req_valid && req_ready |=> !req_ready, "request taken while busy")

	// No result is shown during reset.
	`AAT_ASSERT_RST(a_rst_quiet, !arst_n |-> !rsp_valid, "result valid during reset")

endmodule

bind allocation_tracking_table aat_checker u_aat_checker (.*);
